// ===== hw/rtl/tdp_pkg.sv =====
// Package for the trial-division prime test: widths, word types, control types.
`default_nettype none
package tdp_pkg;

  // Width of the tested value.
  localparam int DATA_WIDTH = 32;
  // A divisor that can still pass d*d <= value needs half the width plus one bit.
  localparam int DIV_W = DATA_WIDTH / 2 + 1;
  // The running square d*d may step just past the largest positive value.
  localparam int SQ_W = DATA_WIDTH + 1;
  // Counter over the bits of the dividend.
  localparam int BIT_CNT_W = $clog2(DATA_WIDTH);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(DATA_WIDTH - 1);
  // The first divisor tried, and its square.
  localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);
  localparam logic [SQ_W-1:0] FIRST_SQUARE = SQ_W'(4);
  localparam logic [DATA_WIDTH-1:0] SMALLEST_PRIME = DATA_WIDTH'(2);

  // Input word.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_element;
  } tdp_in_t;

  // Result word.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_out;
    logic                         is_prime;
    logic                         last_out;
  } tdp_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST
  } tdp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word, set divisor to two
    logic begin_div;  // clear remainder, load dividend shifter
    logic div_step;   // one restoring-division bit
    logic next_div;   // advance divisor and its square
    logic finish;     // register the result and strobe it
    logic prime;      // verdict that goes with finish
  } tdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;  // negative, zero or one
    logic sq_le;      // divisor squared does not exceed the value
    logic div_last;   // the current division step is the last one
    logic rem_zero;   // the finished remainder is zero
  } tdp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime test.
//
//   Channel   Handshake          Word
//   input     start / busy       item   (value, last_element)
//   result    done strobe        result (value_out, is_prime, last_out)
//
// A word is taken when start is high and busy is low. Each divisor tried
// goes through one bound check, DATA_WIDTH bit-serial remainder steps and
// one zero test; the remainder loop sets the time a word takes. Values
// below two finish at the first bound check, without any division.
// Reset is synchronous and leaves the block idle. The result is shown for
// one cycle with done high; it cannot be held off.
`default_nettype none
module trial_division_prime_test (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tdp_pkg::tdp_in_t item,
  output tdp_pkg::tdp_out_t     result,
  output logic                  done
);
  import tdp_pkg::*;

  tdp_cmd_t    cmd;
  tdp_status_t status;

  // Sequencer.
  tdp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // Arithmetic and result register.
  tdp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .done   (done)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tdp_ctrl.sv =====
// Controller state machine for the trial-division prime test.
`default_nettype none
module tdp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output tdp_pkg::tdp_cmd_t        cmd,
  input  wire tdp_pkg::tdp_status_t status
);
  import tdp_pkg::*;

  tdp_state_t state;
  tdp_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.below_two || !status.sq_le) state_next = ST_IDLE;
        else state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (status.rem_zero) state_next = ST_IDLE;
        else state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands and busy.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        if (status.below_two) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b0;
        end else if (!status.sq_le) begin
          // Divisors ran out without a hit.
          cmd.finish = 1'b1;
          cmd.prime  = 1'b1;
        end else begin
          cmd.begin_div = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b0;
        end else begin
          cmd.next_div = 1'b1;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tdp_datapath.sv =====
// Datapath for the trial-division prime test: divisor, square, bit-serial remainder.
`default_nettype none
module tdp_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tdp_pkg::tdp_in_t    item,
  input  wire tdp_pkg::tdp_cmd_t   cmd,
  output tdp_pkg::tdp_status_t     status,
  output tdp_pkg::tdp_out_t        result,
  output logic                     done
);
  import tdp_pkg::*;

  logic [DATA_WIDTH-1:0] held_value;
  logic                  held_last;
  logic [DIV_W-1:0]      divisor;
  logic [SQ_W-1:0]       square;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DIV_W-1:0]      remainder;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic [DIV_W-1:0]      remainder_next;
  logic [SQ_W-1:0]       square_next;

  // One restoring-division bit: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {remainder, dividend[DATA_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) remainder_next = diff[DIV_W-1:0];
    else remainder_next = trial[DIV_W-1:0];
  end

  // (d+1)^2 = d^2 + 2d + 1.
  assign square_next = square + SQ_W'({divisor, 1'b1});

  // Operand and iteration registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_value <= item.value;
      held_last  <= item.last_element;
      divisor    <= FIRST_DIVISOR;
      square     <= FIRST_SQUARE;
    end
    if (cmd.next_div) begin
      divisor <= divisor + DIV_W'(1);
      square  <= square_next;
    end
    if (cmd.begin_div) begin
      dividend  <= held_value;
      remainder <= '0;
      bit_cnt   <= '0;
    end
    if (cmd.div_step) begin
      dividend  <= {dividend[DATA_WIDTH-2:0], 1'b0};
      remainder <= remainder_next;
      bit_cnt   <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  // Status to the controller.
  always_comb begin
    status.below_two = held_value[DATA_WIDTH-1] || (held_value < SMALLEST_PRIME);
    status.sq_le     = square <= {1'b0, held_value};
    status.div_last  = bit_cnt == LAST_BIT;
    status.rem_zero  = remainder == '0;
  end

  // Result word register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      result.value_out <= held_value;
      result.is_prime  <= cmd.prime;
      result.last_out  <= held_last;
    end
  end

endmodule
`default_nettype wire
